/* sv/knk_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package knk_pkg;

    // Field widths of the stream beats and the configuration port.
    localparam int AXIS_W        = 16;
    localparam int STAMP_W       = 32;
    localparam int OP_W          = 2;
    localparam int IN_DATA_W     = 128;
    localparam int OUT_DATA_W    = 56;
    localparam int CFG_W         = 16;
    localparam int NUM_CFG       = 8;
    localparam int APB_AW        = 5;
    localparam int APB_DW        = 32;
    localparam int TIME_BITS_DEF = 32;

    // Square root datapath: three squares of 17-bit differences fit in 34 bits.
    localparam int SQ_OP_W = AXIS_W + 1;
    localparam int RAD_W   = 2 * SQ_OP_W;
    localparam int ROOT_W  = SQ_OP_W;

    localparam logic [AXIS_W-1:0] LEVEL_MAX = '1;

    // Command codes carried in the input tuser.
    typedef enum logic [OP_W-1:0] {
        OP_SAMPLE = 2'd0,
        OP_ARM    = 2'd1,
        OP_CLEAR  = 2'd2
    } opcode_t;

    // Register map, in word order.
    typedef enum logic [2:0] {
        REG_TAP_IMPULSE_MIN     = 3'd0,
        REG_TAP_DEVIATION_MIN   = 3'd1,
        REG_TAP_ROTATION_MAX    = 3'd2,
        REG_QUIET_IMPULSE_MAX   = 3'd3,
        REG_QUIET_DEVIATION_MAX = 3'd4,
        REG_SETTLE_MS           = 3'd5,
        REG_REARM_MS            = 3'd6,
        REG_DEBOUNCE_MS         = 3'd7
    } cfg_index_t;

    localparam logic [CFG_W-1:0] CFG_RESET [NUM_CFG] = '{
        16'd18, 16'd12, 16'd25, 16'd8, 16'd8, 16'd180, 16'd110, 16'd300
    };

    // Handshake status of the square root unit.
    typedef struct packed {
        logic busy;
        logic done;
    } sqrt_status_t;

endpackage

`default_nettype wire

/* sv/imu_knock_detector.sv */
`timescale 1ns / 1ps
`default_nettype none

// Knock detector for a six-axis IMU stream.
// Input beats carry a command in s_tuser and the three acceleration axes, three gyro
// rates and a millisecond stamp in s_tdata. A sample command yields one result beat
// on the m_ side; arm and clear commands reset the detector state and yield nothing.
// Thresholds and timing windows are set through the APB port; the user must write them only
// while the block is idle, which the block itself does not enforce. A sample runs through one
// shared squarer and one bit-serial square root unit: the magnitude root, then (from the second
// sample after reset, arm or clear on) the impulse root. s_tready is high only while the
// sequencer is idle, so no new beat is taken until the last result is loaded; arm and clear
// are done in the idle state. A result waits in the output register while the receiver stalls,
// and the next beat is still accepted; its result waits until the register is free.
// Reset loads the default thresholds, clears the gravity baseline, the tap history
// and the armed flag, and drops m_tvalid.
module imu_knock_detector
    import knk_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // Input stream.
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // accel_x, accel_y, accel_z, rate_x, rate_y, rate_z, stamp_ms
    input  wire logic [IN_DATA_W-1:0]  s_tdata,
    // opcode
    input  wire logic [OP_W-1:0]       s_tuser,
    // Result stream.
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // tap_fired, is_armed, impulse_level, deviation_level, rotation_peak, zero fill
    output logic [OUT_DATA_W-1:0]      m_tdata,
    // Configuration port.
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_AW-1:0]     paddr,
    input  wire logic [APB_DW-1:0]     pwdata,
    output logic [APB_DW-1:0]          prdata,
    output logic                       pready
);

    localparam int STAMP_BITS = (TIME_BITS < STAMP_W) ? TIME_BITS : STAMP_W;
    localparam int STAMP_LSB  = 6 * AXIS_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ,
        ST_ROOT,
        ST_WAIT,
        ST_MAG,
        ST_DECIDE,
        ST_EMIT
    } state_t;

    state_t                       state_reg;
    logic                         phase_reg;
    logic [1:0]                   cnt_reg;

    logic [CFG_W-1:0]             cfg_reg [NUM_CFG];

    logic signed [AXIS_W-1:0]     accel_reg [3];
    logic signed [AXIS_W-1:0]     rate_reg [3];
    logic [TIME_BITS-1:0]         now_reg;

    logic [RAD_W-1:0]             prod_reg;
    logic [RAD_W-1:0]             acc_reg;
    logic [AXIS_W-1:0]            mag_reg;
    logic [AXIS_W-1:0]            dev_reg;
    logic [AXIS_W-1:0]            peak_reg;
    logic [AXIS_W-1:0]            imp_reg;
    logic                         deb_reg;
    logic                         tap_reg;

    logic [AXIS_W-1:0]            gravity_reg;
    logic signed [AXIS_W-1:0]     last_accel_reg [3];
    logic [TIME_BITS-1:0]         last_tap_reg;
    logic [TIME_BITS-1:0]         quiet_since_reg;
    logic                         seen_reg;
    logic                         armed_reg;

    logic                         m_tvalid_reg;
    logic [OUT_DATA_W-1:0]        m_tdata_reg;

    sqrt_status_t                 sqrt_status;
    logic [ROOT_W-1:0]            sqrt_root;
    logic                         sqrt_start;

    logic                         s_accept;
    logic                         cfg_write;
    logic [TIME_BITS-1:0]         now_in;

    logic signed [AXIS_W-1:0]     sel_accel;
    logic signed [AXIS_W-1:0]     sel_last;
    logic signed [SQ_OP_W-1:0]    sq_op;
    logic signed [RAD_W-1:0]      sq_prod;

    logic [AXIS_W-1:0]            grav_eff;
    logic [AXIS_W:0]              mag_diff;
    logic [AXIS_W-1:0]            dev_w;
    logic [AXIS_W-1:0]            abs_rate [3];
    logic [AXIS_W-1:0]            peak_w;
    logic                         deb_w;

    logic [AXIS_W:0]              g_diff;
    logic [AXIS_W:0]              g_abs;
    logic [AXIS_W:0]              g_shr;
    logic [AXIS_W:0]              g_step;
    logic [AXIS_W:0]              g_sum;
    logic                         quiet_w;
    logic [TIME_BITS-1:0]         qs_w;
    logic [CFG_W-1:0]             need_w;
    logic                         armed_w;
    logic                         tap_w;

    // Elapsed-time check; a stamp below the reference never satisfies a wait.
    function automatic logic elapsed(input logic [TIME_BITS-1:0] now_t,
                                     input logic [TIME_BITS-1:0] ref_t,
                                     input logic [CFG_W-1:0] need);
        logic [TIME_BITS-1:0] gap;
        gap = now_t - ref_t;
        return (now_t >= ref_t) && (gap >= TIME_BITS'(need));
    endfunction

    function automatic logic [AXIS_W-1:0] abs16(input logic signed [AXIS_W-1:0] v);
        logic [AXIS_W:0] w;
        w = {v[AXIS_W-1], v};
        return w[AXIS_W] ? AXIS_W'(-w) : w[AXIS_W-1:0];
    endfunction

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_write = psel && penable && pwrite && pready;
    assign now_in    = TIME_BITS'(s_tdata[STAMP_LSB +: STAMP_BITS]);

    // Configuration read path.
    assign pready = 1'b1;
    assign prdata = {{(APB_DW - CFG_W){1'b0}}, cfg_reg[paddr[4:2]]};

    // Operand of the shared squarer: an axis, or its change since the last sample.
    always_comb begin
        sel_accel = accel_reg[0];
        sel_last  = last_accel_reg[0];
        case (cnt_reg)
            2'd1: begin
                sel_accel = accel_reg[1];
                sel_last  = last_accel_reg[1];
            end
            2'd2: begin
                sel_accel = accel_reg[2];
                sel_last  = last_accel_reg[2];
            end
            default: ;
        endcase
        sq_op = phase_reg ? ({sel_accel[AXIS_W-1], sel_accel} - {sel_last[AXIS_W-1], sel_last})
                          : {sel_accel[AXIS_W-1], sel_accel};
    end

    assign sq_prod = sq_op * sq_op;

    // Deviation from the baseline, rotation peak and debounce state.
    always_comb begin
        grav_eff = (gravity_reg == '0) ? mag_reg : gravity_reg;
        mag_diff = {1'b0, mag_reg} - {1'b0, grav_eff};
        dev_w    = mag_diff[AXIS_W] ? AXIS_W'(-mag_diff) : mag_diff[AXIS_W-1:0];
        for (int i = 0; i < 3; i++) begin
            abs_rate[i] = abs16(rate_reg[i]);
        end
        peak_w = abs_rate[0];
        if (abs_rate[1] > peak_w) begin
            peak_w = abs_rate[1];
        end
        if (abs_rate[2] > peak_w) begin
            peak_w = abs_rate[2];
        end
        deb_w = (last_tap_reg == '0) ||
                elapsed(now_reg, last_tap_reg, cfg_reg[REG_DEBOUNCE_MS]);
    end

    // Quiet tracking, arming and the tap decision.
    always_comb begin
        g_diff  = {1'b0, mag_reg} - {1'b0, gravity_reg};
        g_abs   = g_diff[AXIS_W] ? (AXIS_W + 1)'(-g_diff) : g_diff;
        g_shr   = g_abs >> 4;
        g_step  = g_diff[AXIS_W] ? (AXIS_W + 1)'(-g_shr) : g_shr;
        g_sum   = {1'b0, gravity_reg} + g_step;
        quiet_w = (imp_reg <= cfg_reg[REG_QUIET_IMPULSE_MAX]) &&
                  (dev_reg <= cfg_reg[REG_QUIET_DEVIATION_MAX]);
        qs_w    = (quiet_since_reg == '0) ? now_reg : quiet_since_reg;
        need_w  = (last_tap_reg == '0) ? cfg_reg[REG_SETTLE_MS] : cfg_reg[REG_REARM_MS];
        armed_w = armed_reg;
        if (quiet_w && deb_reg && elapsed(now_reg, qs_w, need_w)) begin
            armed_w = 1'b1;
        end
        tap_w = armed_w && deb_reg &&
                (imp_reg >= cfg_reg[REG_TAP_IMPULSE_MIN]) &&
                (dev_reg >= cfg_reg[REG_TAP_DEVIATION_MIN]) &&
                (peak_reg <= cfg_reg[REG_TAP_ROTATION_MAX]);
    end

    assign sqrt_start = (state_reg == ST_ROOT);

    knk_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (acc_reg),
        .status   (sqrt_status),
        .root     (sqrt_root)
    );

    // Sequencer, detector state, configuration and output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            phase_reg       <= 1'b0;
            cnt_reg         <= '0;
            m_tvalid_reg    <= 1'b0;
            gravity_reg     <= '0;
            last_tap_reg    <= '0;
            quiet_since_reg <= '0;
            seen_reg        <= 1'b0;
            armed_reg       <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                last_accel_reg[i] <= '0;
            end
            for (int i = 0; i < NUM_CFG; i++) begin
                cfg_reg[i] <= CFG_RESET[i];
            end
        end else begin
            if (cfg_write) begin
                cfg_reg[paddr[4:2]] <= pwdata[CFG_W-1:0];
            end
            // The emit state reloads the output register itself.
            if (m_tvalid_reg && m_tready && (state_reg != ST_EMIT)) begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        for (int i = 0; i < 3; i++) begin
                            accel_reg[i] <= s_tdata[i*AXIS_W +: AXIS_W];
                            rate_reg[i]  <= s_tdata[(i+3)*AXIS_W +: AXIS_W];
                        end
                        now_reg <= now_in;
                        case (s_tuser) inside
                            OP_SAMPLE: begin
                                phase_reg <= 1'b0;
                                cnt_reg   <= '0;
                                state_reg <= ST_SQ;
                            end
                            OP_ARM, OP_CLEAR: begin
                                gravity_reg  <= '0;
                                last_tap_reg <= '0;
                                seen_reg     <= 1'b0;
                                armed_reg    <= 1'b0;
                                for (int i = 0; i < 3; i++) begin
                                    last_accel_reg[i] <= '0;
                                end
                                quiet_since_reg <= (s_tuser == OP_ARM) ? now_in : '0;
                            end
                            default: ;
                        endcase
                    end
                end

                // Three squares through one multiplier, each accumulated in the cycle after it is registered.
                ST_SQ: begin
                    prod_reg <= sq_prod;
                    acc_reg  <= (cnt_reg == 2'd0) ? '0 : (acc_reg + prod_reg);
                    cnt_reg  <= cnt_reg + 1'b1;
                    if (cnt_reg == 2'd3) begin
                        state_reg <= ST_ROOT;
                    end
                end

                ST_ROOT: begin
                    state_reg <= ST_WAIT;
                end

                ST_WAIT: begin
                    if (sqrt_status.done) begin
                        if (!phase_reg) begin
                            mag_reg   <= sqrt_root[AXIS_W-1:0];
                            state_reg <= ST_MAG;
                        end else begin
                            imp_reg   <= sqrt_root[ROOT_W-1] ? LEVEL_MAX
                                                             : sqrt_root[AXIS_W-1:0];
                            state_reg <= ST_DECIDE;
                        end
                    end
                end

                // Baseline load, deviation, peak; the first sample ends here.
                ST_MAG: begin
                    gravity_reg <= grav_eff;
                    dev_reg     <= dev_w;
                    peak_reg    <= peak_w;
                    deb_reg     <= deb_w;
                    if (!seen_reg) begin
                        for (int i = 0; i < 3; i++) begin
                            last_accel_reg[i] <= accel_reg[i];
                        end
                        seen_reg        <= 1'b1;
                        quiet_since_reg <= now_reg;
                        imp_reg         <= '0;
                        tap_reg         <= 1'b0;
                        state_reg       <= ST_EMIT;
                    end else begin
                        phase_reg <= 1'b1;
                        cnt_reg   <= '0;
                        state_reg <= ST_SQ;
                    end
                end

                ST_DECIDE: begin
                    for (int i = 0; i < 3; i++) begin
                        last_accel_reg[i] <= accel_reg[i];
                    end
                    if (quiet_w) begin
                        quiet_since_reg <= qs_w;
                        gravity_reg     <= g_sum[AXIS_W-1:0];
                    end else begin
                        quiet_since_reg <= '0;
                    end
                    tap_reg <= tap_w;
                    if (tap_w) begin
                        armed_reg    <= 1'b0;
                        last_tap_reg <= now_reg;
                    end else begin
                        armed_reg <= armed_w;
                    end
                    state_reg <= ST_EMIT;
                end

                // Load the result once the output register is free.
                ST_EMIT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {{(OUT_DATA_W - 3*AXIS_W - 2){1'b0}},
                                         peak_reg, dev_reg, imp_reg, armed_reg, tap_reg};
                        state_reg    <= ST_IDLE;
                    end
                end

                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    // A sample command keeps the input closed on the following cycle.
    a_sample_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == OP_SAMPLE) |=> !s_tready)
        else $error("input still open after a sample beat");

    // A tap always disarms the detector.
    a_tap_disarms: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[0] && m_tdata[1]))
        else $error("tap reported while still armed");

    // The magnitude root of three 16-bit squares fits in 16 bits.
    a_mag_range: assert property (@(posedge aclk) disable iff (!aresetn)
        sqrt_status.done && !phase_reg |-> !sqrt_root[ROOT_W-1])
        else $error("magnitude root overflow");

    // The root unit is only started when it is free.
    a_sqrt_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ROOT) |-> !sqrt_status.busy)
        else $error("square root started while busy");
`endif

endmodule

`default_nettype wire

/* sv/knk_sqrt.sv */
`timescale 1ns / 1ps
`default_nettype none

// Digit-by-digit floor square root, one result bit per cycle.
module knk_sqrt
    import knk_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [RAD_W-1:0]  radicand,
    output sqrt_status_t           status,
    output logic [ROOT_W-1:0]      root
);

    localparam int CNT_W = $clog2(ROOT_W);
    localparam int REM_W = ROOT_W + 1;

    logic [RAD_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [REM_W+1:0]  rem_sh;
    logic [REM_W+1:0]  trial;
    logic              take;
    logic [REM_W+1:0]  rem_diff;

    // Bring down the next two radicand bits and try the next root bit.
    always_comb begin
        rem_sh   = {rem_reg, rad_reg[RAD_W-1 -: 2]};
        trial    = {1'b0, root_reg, 2'b01};
        take     = (rem_sh >= trial);
        rem_diff = take ? (rem_sh - trial) : rem_sh;
    end

    // Iteration registers; the done flag is a single-cycle pulse.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                rad_reg  <= radicand;
                rem_reg  <= '0;
                root_reg <= '0;
                cnt_reg  <= CNT_W'(ROOT_W - 1);
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rad_reg  <= rad_reg << 2;
                rem_reg  <= rem_diff[REM_W-1:0];
                root_reg <= {root_reg[ROOT_W-2:0], take};
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign root        = root_reg;

endmodule

`default_nettype wire
